// ----- sv/dbfd_pkg.sv -----
package dbfd_pkg;

  localparam int TickW  = 15;
  localparam int ByteW  = 8;
  localparam int CountW = 4;
  localparam int IndexW = 4;

  typedef enum logic [1:0] {
    STATUS_COMPLETE  = 2'd0,
    STATUS_EARLY_END = 2'd1,
    STATUS_ILLEGAL   = 2'd2
  } status_t;

  typedef enum logic [IndexW-1:0] {
    REG_SHORT_LOW  = 4'd0,
    REG_SHORT_HIGH = 4'd1,
    REG_LONG_LOW   = 4'd2,
    REG_LONG_HIGH  = 4'd3
  } reg_index_t;

  typedef struct packed {
    logic [TickW-1:0] short_low;
    logic [TickW-1:0] short_high;
    logic [TickW-1:0] long_low;
    logic [TickW-1:0] long_high;
  } windows_t;

  typedef struct packed {
    logic [ByteW-1:0]  frame_byte;
    logic [CountW-1:0] bits_received;
    status_t           status;
  } result_t;

  localparam logic [TickW-1:0] ShortLowReset  = 15'd300;
  localparam logic [TickW-1:0] ShortHighReset = 15'd550;
  localparam logic [TickW-1:0] LongLowReset   = 15'd700;
  localparam logic [TickW-1:0] LongHighReset  = 15'd1000;

endpackage

// ----- sv/dbfd_cfg_regs.sv -----
module dbfd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dbfd_pkg::IndexW-1:0]     cfg_index,
  input  logic [dbfd_pkg::TickW-1:0]      cfg_data,
  output dbfd_pkg::windows_t              windows
);
  import dbfd_pkg::*;

  windows_t windows_next;

  always_comb begin
    windows_next = windows;
    if (cfg_write) begin
      unique case (cfg_index)
        REG_SHORT_LOW:  windows_next.short_low  = cfg_data;
        REG_SHORT_HIGH: windows_next.short_high = cfg_data;
        REG_LONG_LOW:   windows_next.long_low   = cfg_data;
        REG_LONG_HIGH:  windows_next.long_high  = cfg_data;
        default:        windows_next = windows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      windows.short_low  <= ShortLowReset;
      windows.short_high <= ShortHighReset;
      windows.long_low   <= LongLowReset;
      windows.long_high  <= LongHighReset;
    end else begin
      windows <= windows_next;
    end
  end

endmodule

// ----- sv/dbfd_decode.sv -----
module dbfd_decode #(
  parameter int FRAME_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  dbfd_pkg::windows_t          windows,
  input  logic [dbfd_pkg::TickW-1:0]  pulse_ticks,
  input  logic                        pulse_level,
  input  logic                        frame_start,
  input  logic                        capture_end,
  output logic                        emit,
  output dbfd_pkg::result_t           result
);
  import dbfd_pkg::*;

  localparam int FcW = $clog2(FRAME_BITS + 1);
  localparam logic [FcW-1:0] FullCount = FcW'(FRAME_BITS);

  logic             previous_bit, previous_bit_next;
  logic [ByteW-1:0] bit_shifter, bit_shifter_next;
  logic [FcW-1:0]   bit_count, bit_count_next;
  logic             capturing, capturing_next;

  logic             prev_base;
  logic [ByteW-1:0] shift_base;
  logic [FcW-1:0]   count_base;
  logic             cap_base;
  logic             in_short, in_long, add_bit, illegal, full;

  always_comb begin
    prev_base  = frame_start ? 1'b1 : previous_bit;
    shift_base = frame_start ? '0 : bit_shifter;
    count_base = frame_start ? '0 : bit_count;
    cap_base   = frame_start | capturing;

    in_short = (pulse_ticks > windows.short_low) && (pulse_ticks < windows.short_high);
    in_long  = (pulse_ticks > windows.long_low) && (pulse_ticks < windows.long_high);
    add_bit  = cap_base && ((in_short && (pulse_level == prev_base)) ||
                            (!in_short && in_long && (pulse_level != prev_base)));
    illegal  = cap_base && !in_short && in_long && (pulse_level == prev_base);

    previous_bit_next = prev_base;
    bit_shifter_next  = shift_base;
    bit_count_next    = count_base;
    if (add_bit) begin
      previous_bit_next = pulse_level;
      bit_shifter_next  = {shift_base[ByteW-2:0], pulse_level};
      bit_count_next    = count_base + FcW'(1);
    end

    full = bit_count_next >= FullCount;
    emit = cap_base && (illegal || full || capture_end);
    capturing_next = cap_base && !emit;

    result.frame_byte    = bit_shifter_next;
    result.bits_received = CountW'(bit_count_next);
    if (illegal) begin
      result.status = STATUS_ILLEGAL;
    end else if (full) begin
      result.status = STATUS_COMPLETE;
    end else begin
      result.status = STATUS_EARLY_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_bit <= 1'b1;
      bit_shifter  <= '0;
      bit_count    <= '0;
      capturing    <= 1'b0;
    end else if (accept) begin
      previous_bit <= previous_bit_next;
      bit_shifter  <= bit_shifter_next;
      bit_count    <= bit_count_next;
      capturing    <= capturing_next;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bit_count <= FullCount)
    else $error("bit count beyond frame length");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> !capturing)
    else $error("still capturing after a result");

endmodule

// ----- sv/dbfd_out_reg.sv -----
module dbfd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  dbfd_pkg::result_t  result_in,
  input  logic               out_stall,
  output logic               out_valid,
  output dbfd_pkg::result_t  result_out
);
  import dbfd_pkg::*;

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- sv/dali_backward_frame_decoder.sv -----
// a result appears in the output register in the cycle after the pulse that ends the frame is taken
// throughput: one pulse per cycle; input stalls only while a held result is itself stalled
// the decode state (previous bit, shifter, count) updates in the same cycle the pulse is taken
// synchronous active-high reset: windows to 300/550/700/1000 ticks, decoder idle, output empty
module dali_backward_frame_decoder #(
  parameter int FRAME_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [dbfd_pkg::IndexW-1:0] cfg_index,
  input  logic [dbfd_pkg::TickW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dbfd_pkg::TickW-1:0]  pulse_ticks,
  input  logic                        pulse_level,
  input  logic                        frame_start,
  input  logic                        capture_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dbfd_pkg::ByteW-1:0]  frame_byte,
  output logic [dbfd_pkg::CountW-1:0] bits_received,
  output logic [1:0]                  status
);
  import dbfd_pkg::*;

  windows_t windows;
  result_t  result, result_held;
  logic     accept, emit;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  dbfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .windows   (windows)
  );

  dbfd_decode #(
    .FRAME_BITS (FRAME_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .windows     (windows),
    .pulse_ticks (pulse_ticks),
    .pulse_level (pulse_level),
    .frame_start (frame_start),
    .capture_end (capture_end),
    .emit        (emit),
    .result      (result)
  );

  dbfd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .result_in  (result),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .result_out (result_held)
  );

  assign frame_byte    = result_held.frame_byte;
  assign bits_received = result_held.bits_received;
  assign status        = result_held.status;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(accept && out_valid && out_stall))
    else $error("transaction taken over a stalled result");

  a_complete_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_COMPLETE) |-> bits_received == CountW'(FRAME_BITS))
    else $error("complete frame with wrong bit count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule
